// File: rtl/core/itsg_pkg.sv
// ----------------------------------------------------------------------------
// itsg_pkg
// shared widths, reset values, register indexes and types of the isometric
// tile scan generator
// ----------------------------------------------------------------------------
package itsg_pkg;

  localparam int TILE_WIDTH_DEF  = 36;
  localparam int TILE_HEIGHT_DEF = 18;

  localparam int FRAME_W    = 12;  // frame size registers
  localparam int MAP_W      = 10;  // map limits and view centre
  localparam int POS_W      = 12;  // map_x / map_y
  localparam int SCR_W      = 14;  // screen_x / screen_y
  localparam int LAYER_W    = 2;
  localparam int COORD_W    = 14;  // tile offsets inside the walk
  localparam int NUM_LAYERS = 3;
  localparam int CFG_IDX_W  = 2;

  // tile queue between the walker and the result stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [MAP_W-1:0]   MAP_LAST_RST     = 10'd479;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MAP_LAST_X   = 2'd2,
    REG_MAP_LAST_Y   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_NEXT  = 1'b1
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [LAYER_W-1:0]        layer;
    logic                      row_last;
    logic                      frame_last;
  } tile_t;

  typedef struct packed {
    logic push;  // tile word pushed into the queue
    logic fin;   // walk over, nothing held back
  } wk_stat_t;

endpackage

// File: rtl/core/itsg_in_if.sv
// ----------------------------------------------------------------------------
// itsg_in_if
// request channel: start a frame or ask for the next tile
// ----------------------------------------------------------------------------
interface itsg_in_if import itsg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [MAP_W-1:0] center_x;
  logic [MAP_W-1:0] center_y;

  modport source (output valid, output req_type, output center_x, output center_y,
                  input ready);
  modport sink   (input valid, input req_type, input center_x, input center_y,
                  output ready);
endinterface

// File: rtl/core/itsg_out_if.sv
// ----------------------------------------------------------------------------
// itsg_out_if
// result channel: one tile word per request
// ----------------------------------------------------------------------------
interface itsg_out_if import itsg_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    tile_valid;
  logic [LAYER_W-1:0]      layer;
  logic signed [POS_W-1:0] map_x;
  logic signed [POS_W-1:0] map_y;
  logic                    in_range;
  logic signed [SCR_W-1:0] screen_x;
  logic signed [SCR_W-1:0] screen_y;
  logic                    row_last;
  logic                    frame_last;

  modport source (output valid, output tile_valid, output layer, output map_x,
                  output map_y, output in_range, output screen_x, output screen_y,
                  output row_last, output frame_last, input ready);
  modport sink   (input valid, input tile_valid, input layer, input map_x,
                  input map_y, input in_range, input screen_x, input screen_y,
                  input row_last, input frame_last, output ready);
endinterface

// File: rtl/core/itsg_cfg_if.sv
// ----------------------------------------------------------------------------
// itsg_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface itsg_cfg_if import itsg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [FRAME_W-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// File: rtl/core/itsg_walker.sv
// ----------------------------------------------------------------------------
// itsg_walker
// works out the corner offsets from the frame size, then walks the rows of
// the diamond view three times and pushes one tile word per step unless q_full
// ----------------------------------------------------------------------------
module itsg_walker import itsg_pkg::*; #(
  parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
  parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [FRAME_W-1:0] frame_width,
  input  logic [FRAME_W-1:0] frame_height,
  input  logic               q_full,
  output tile_t              tile,
  output wk_stat_t           stat
);

  localparam int W2      = 2 * TILE_WIDTH;
  localparam int H2      = 2 * TILE_HEIGHT;
  localparam int RSH     = 16;
  localparam int RECIP_W = (1 << RSH) / W2;
  localparam int RECIP_H = (1 << RSH) / H2;
  localparam int MUL_W   = FRAME_W + RSH + 1;
  localparam logic [LAYER_W-1:0] LAST_LAYER = LAYER_W'(NUM_LAYERS - 1);
  localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1);
  localparam logic signed [COORD_W-1:0] TWO = COORD_W'(2);

  typedef enum logic [5:0] {
    WK_MUL  = 6'b000001,
    WK_DIV  = 6'b000010,
    WK_CRN  = 6'b000100,
    WK_ROW  = 6'b001000,
    WK_TILE = 6'b010000,
    WK_DONE = 6'b100000
  } wk_mode_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_TOP    = 5'b00010,
    PH_LEFT   = 5'b00100,
    PH_BOTTOM = 5'b01000,
    PH_LOWER  = 5'b10000
  } wk_phase_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tr_x;
    logic signed [COORD_W-1:0] tr_y;
    logic signed [COORD_W-1:0] tl_x;
    logic signed [COORD_W-1:0] tl_y;
    logic signed [COORD_W-1:0] rt_x;
    logic signed [COORD_W-1:0] rt_y;
    logic signed [COORD_W-1:0] rb_x;
    logic signed [COORD_W-1:0] rb_y;
    logic signed [COORD_W-1:0] br_y;
    logic signed [COORD_W-1:0] lt_y;
    logic signed [COORD_W-1:0] lb_y;
  } crn_t;

  wk_mode_t  mode_r, mode_nxt;
  wk_phase_t phase_r, phase_nxt, nph;
  logic [LAYER_W-1:0] layer_r, layer_nxt;
  logic signed [COORD_W-1:0] bx_r, by_r, ex_r, ey_r, cx_r;
  logic signed [COORD_W-1:0] bx_nxt, by_nxt, ex_nxt, ey_nxt, cx_nxt;
  tile_t hold_r, hold_nxt, em_tile;
  logic  hold_v_r, hold_v_nxt, emit, push;

  // frame size split into tile counts
  logic [MUL_W-1:0]   wprod, hprod;
  logic [FRAME_W-1:0] r_est_r, s_est_r;
  logic [FRAME_W-1:0] p_est, q_est, r_fix, s_fix, p_fix, q_fix;
  logic               sh_c, sv_c, sh_r, sv_r;
  logic signed [COORD_W-1:0] n_c, m_c, n_r, m_r;
  logic signed [COORD_W-1:0] ca, cb, cc, cd;
  crn_t crn_c, crn_r;

  // row stepping
  logic bhit, ehit, term, nonempty;
  logic signed [COORD_W-1:0] bt_x, bt_y, et_x, et_y;
  logic signed [COORD_W-1:0] nb_x, nb_y, ne_x, ne_y, cx_inc;

  assign wprod = MUL_W'(frame_width) * MUL_W'(RECIP_W);
  assign hprod = MUL_W'(frame_height) * MUL_W'(RECIP_H);

  // reciprocal estimate is low by at most one
  always_comb begin
    p_est = frame_width - FRAME_W'(r_est_r * W2);
    q_est = frame_height - FRAME_W'(s_est_r * H2);
    r_fix = r_est_r;
    p_fix = p_est;
    s_fix = s_est_r;
    q_fix = q_est;
    if (p_est >= FRAME_W'(W2)) begin
      r_fix = r_est_r + 1'b1;
      p_fix = p_est - FRAME_W'(W2);
    end
    if (q_est >= FRAME_W'(H2)) begin
      s_fix = s_est_r + 1'b1;
      q_fix = q_est - FRAME_W'(H2);
    end
    sh_c = !((p_fix > FRAME_W'(TILE_WIDTH)) || (p_fix == '0));
    sv_c = (q_fix > FRAME_W'(TILE_HEIGHT)) || (q_fix == '0);
    n_c  = COORD_W'(r_fix) + COORD_W'(p_fix != '0) - COORD_W'(sh_c);
    m_c  = COORD_W'(s_fix) + COORD_W'(q_fix != '0);
  end

  // four stagger cases of the corner set
  always_comb begin
    ca = n_r - m_r;
    cb = -m_r - n_r;
    cc = m_r + n_r;
    cd = m_r - n_r;
    crn_c.tr_x = ca;
    crn_c.tr_y = cb;
    crn_c.tl_x = cb;
    crn_c.tl_y = ca;
    crn_c.rt_x = ca;
    crn_c.rt_y = cb;
    crn_c.rb_x = cc - ONE;
    crn_c.rb_y = cd - ONE;
    crn_c.br_y = cd - ONE;
    crn_c.lt_y = ca;
    crn_c.lb_y = cc - ONE;
    case ({sh_r, sv_r})
      2'b00: begin
      end
      2'b11: begin
        crn_c.tr_y = cb - ONE;
        crn_c.tl_x = cb - ONE;
        crn_c.rt_y = cb - ONE;
        crn_c.rb_x = cc;
        crn_c.lb_y = cc;
      end
      2'b10: begin
        crn_c.rt_x = ca + ONE;
        crn_c.rb_y = cd - TWO;
        crn_c.lt_y = ca + ONE;
      end
      default: begin
        crn_c.tr_x = ca - ONE;
        crn_c.tl_y = ca - ONE;
        crn_c.br_y = cd;
      end
    endcase
  end

  // one row step
  always_comb begin
    bhit = (bx_r == crn_r.tl_x) && (by_r == crn_r.tl_y);
    ehit = (ex_r == crn_r.rb_x) && (ey_r == crn_r.rb_y);
    term = (phase_r != PH_IDLE) && (by_r >= crn_r.lb_y);
    // start reached the top-left corner: clamp or go down the left edge
    bt_x = bx_r + ONE;
    bt_y = by_r + ONE;
    if (by_r < crn_r.lt_y) begin
      bt_x = bx_r;
      bt_y = crn_r.lt_y;
    end
    // end reached the right-bottom corner: clamp or go along the bottom edge
    et_x = ex_r - ONE;
    et_y = ey_r + ONE;
    if (ey_r < crn_r.br_y) begin
      et_x = ex_r;
      et_y = crn_r.br_y;
    end
    nb_x = bx_r + ONE;
    nb_y = by_r + ONE;
    ne_x = ex_r - ONE;
    ne_y = ey_r + ONE;
    nph  = PH_LOWER;
    case (phase_r)
      PH_IDLE: begin
        nb_x = crn_r.tr_x;
        nb_y = crn_r.tr_y;
        ne_x = crn_r.rt_x;
        ne_y = crn_r.rt_y;
        nph  = PH_TOP;
      end
      PH_TOP: begin
        nb_x = bhit ? bt_x : bx_r - ONE;
        nb_y = bhit ? bt_y : by_r + ONE;
        ne_x = ehit ? et_x : ex_r + ONE;
        ne_y = ehit ? et_y : ey_r + ONE;
        if (bhit && ehit) nph = PH_LOWER;
        else if (bhit)    nph = PH_LEFT;
        else if (ehit)    nph = PH_BOTTOM;
        else              nph = PH_TOP;
      end
      PH_LEFT: begin
        ne_x = ehit ? et_x : ex_r + ONE;
        ne_y = ehit ? et_y : ey_r + ONE;
        nph  = ehit ? PH_LOWER : PH_LEFT;
      end
      PH_BOTTOM: begin
        nb_x = bhit ? bt_x : bx_r - ONE;
        nb_y = bhit ? bt_y : by_r + ONE;
        nph  = bhit ? PH_LOWER : PH_BOTTOM;
      end
      default: begin
      end
    endcase
    nonempty = nb_x <= ne_x;
    cx_inc   = cx_r + ONE;
  end

  // walk sequencer
  always_comb begin
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    layer_nxt  = layer_r;
    bx_nxt     = bx_r;
    by_nxt     = by_r;
    ex_nxt     = ex_r;
    ey_nxt     = ey_r;
    cx_nxt     = cx_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    emit       = 1'b0;
    push       = 1'b0;
    tile       = hold_r;
    em_tile    = '0;
    em_tile.layer = layer_r;
    case (mode_r)
      WK_MUL: mode_nxt = WK_DIV;
      WK_DIV: mode_nxt = WK_CRN;
      WK_CRN: begin
        mode_nxt  = WK_ROW;
        phase_nxt = PH_IDLE;
        layer_nxt = '0;
      end
      WK_ROW, WK_TILE: begin
        if (!q_full) begin
          if (mode_r == WK_TILE && cx_r != ex_r) begin
            cx_nxt           = cx_inc;
            emit             = 1'b1;
            em_tile.dx       = cx_inc;
            em_tile.dy       = by_r;
            em_tile.row_last = cx_inc == ex_r;
          end else if (term) begin
            if (layer_r == LAST_LAYER) begin
              mode_nxt = WK_DONE;
            end else begin
              mode_nxt  = WK_ROW;
              layer_nxt = layer_r + 1'b1;
              phase_nxt = PH_IDLE;
            end
          end else begin
            bx_nxt    = nb_x;
            by_nxt    = nb_y;
            ex_nxt    = ne_x;
            ey_nxt    = ne_y;
            phase_nxt = nph;
            if (nonempty) begin
              mode_nxt         = WK_TILE;
              cx_nxt           = nb_x;
              emit             = 1'b1;
              em_tile.dx       = nb_x;
              em_tile.dy       = nb_y;
              em_tile.row_last = nb_x == ne_x;
            end else begin
              mode_nxt = WK_ROW;
            end
          end
        end
      end
      WK_DONE: begin
        // the held tile is the last one of the frame
        if (!q_full && hold_v_r) begin
          push            = 1'b1;
          tile.frame_last = 1'b1;
          hold_v_nxt      = 1'b0;
        end
      end
      default: mode_nxt = WK_DONE;
    endcase
    if (emit) begin
      push       = hold_v_r;
      hold_nxt   = em_tile;
      hold_v_nxt = 1'b1;
    end
  end

  assign stat.push = push;
  assign stat.fin  = (mode_r == WK_DONE) && !hold_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= WK_DONE;
      phase_r  <= PH_IDLE;
      layer_r  <= '0;
      hold_v_r <= 1'b0;
    end else if (start) begin
      mode_r   <= WK_MUL;
      phase_r  <= PH_IDLE;
      layer_r  <= '0;
      hold_v_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      phase_r  <= phase_nxt;
      layer_r  <= layer_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mode_r == WK_MUL) begin
      r_est_r <= wprod[RSH +: FRAME_W];
      s_est_r <= hprod[RSH +: FRAME_W];
    end
    if (mode_r == WK_DIV) begin
      n_r  <= n_c;
      m_r  <= m_c;
      sh_r <= sh_c;
      sv_r <= sv_c;
    end
    if (mode_r == WK_CRN) begin
      crn_r <= crn_c;
    end
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    cx_r   <= cx_nxt;
    hold_r <= hold_nxt;
  end

endmodule

// File: rtl/core/isometric_tile_scan_generator.sv
// ----------------------------------------------------------------------------
// isometric_tile_scan_generator
// tile visiting order for an isometric diamond map view, three layers
// ----------------------------------------------------------------------------
// channel   dir  handshake        word
// in_chan   in   valid / ready    req_type, center_x, center_y
// out_chan  out  valid / ready    tile_valid .. frame_last, one per request
// cfg_chan  in   valid / ready    addr, data (always ready)
//
// a start passes through the walker steps multiply, divide fix-up, corners and
// first row before its first tile, which is held back until the next tile or
// the end of the walk so that it can take the frame-end mark; the walker then
// makes one tile per cycle along a row while the queue is not full.
// the walker runs ahead into a four-word queue; each layer change and each empty
// row takes the walker a step with no tile, hidden while the queue holds words.
// reset is synchronous; registers come back at 640 x 480 and 479 / 479.
// a stalled result holds in the output register while the next request waits.
// ----------------------------------------------------------------------------
module isometric_tile_scan_generator import itsg_pkg::*; #(
  parameter int TILE_WIDTH  = TILE_WIDTH_DEF,
  parameter int TILE_HEIGHT = TILE_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itsg_in_if.sink    in_chan,
  itsg_out_if.source out_chan,
  itsg_cfg_if.sink   cfg_chan
);

  localparam int HALF_W = TILE_WIDTH / 2;
  localparam int HALF_H = TILE_HEIGHT / 2;

  logic [FRAME_W-1:0] frame_width_r, frame_height_r;
  logic [MAP_W-1:0]   map_last_x_r, map_last_y_r;
  logic [MAP_W-1:0]   center_x_r, center_y_r;

  logic req_v_r, active_r;
  logic in_acc, start_acc, out_free, req_go, tile_ok;

  tile_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  q_head_r, q_tail_r;
  logic [QPTR_W:0]    q_cnt_r;
  logic               q_full, q_pop;
  tile_t              head, wk_tile;
  wk_stat_t           wk_stat;

  logic signed [COORD_W:0] ax, ay, lim_x, lim_y;
  logic                    inr;
  logic [SCR_W-1:0]        dd, ds, sx, sy;

  logic                    out_v_r;
  logic                    out_tile_valid_r;
  logic [LAYER_W-1:0]      out_layer_r;
  logic signed [POS_W-1:0] out_map_x_r, out_map_y_r;
  logic                    out_in_range_r;
  logic signed [SCR_W-1:0] out_screen_x_r, out_screen_y_r;
  logic                    out_row_last_r, out_frame_last_r;

  // register writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      map_last_x_r   <= MAP_LAST_RST;
      map_last_y_r   <= MAP_LAST_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.addr))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_chan.data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_chan.data;
        REG_MAP_LAST_X:   map_last_x_r   <= cfg_chan.data[MAP_W-1:0];
        REG_MAP_LAST_Y:   map_last_y_r   <= cfg_chan.data[MAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request slot
  assign out_free  = !out_v_r || out_chan.ready;
  assign tile_ok   = active_r && (q_cnt_r != '0);
  assign req_go    = req_v_r && out_free && (!active_r || (q_cnt_r != '0) || wk_stat.fin);
  assign in_chan.ready = !req_v_r || req_go;
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign start_acc = in_acc && (in_chan.req_type == REQ_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      if (in_acc)      req_v_r <= 1'b1;
      else if (req_go) req_v_r <= 1'b0;
      if (start_acc)                active_r <= 1'b1;
      else if (req_go && !tile_ok)  active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      center_x_r <= in_chan.center_x;
      center_y_r <= in_chan.center_y;
    end
  end

  itsg_walker #(
    .TILE_WIDTH  (TILE_WIDTH),
    .TILE_HEIGHT (TILE_HEIGHT)
  ) u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start_acc),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_full       (q_full),
    .tile         (wk_tile),
    .stat         (wk_stat)
  );

  // tile queue, flushed by a start
  assign q_full = q_cnt_r == (QPTR_W+1)'(QDEPTH);
  assign q_pop  = req_go && tile_ok;
  assign head   = q_mem_r[q_head_r];

  always_ff @(posedge clk) begin
    if (!rst_n || start_acc) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (wk_stat.push) q_tail_r <= q_tail_r + 1'b1;
      if (q_pop)        q_head_r <= q_head_r + 1'b1;
      q_cnt_r <= q_cnt_r + (QPTR_W+1)'(wk_stat.push) - (QPTR_W+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wk_stat.push) q_mem_r[q_tail_r] <= wk_tile;
  end

  // result fields use the current registers
  always_comb begin
    ax    = (COORD_W+1)'($signed({1'b0, center_x_r})) + (COORD_W+1)'(head.dx);
    ay    = (COORD_W+1)'($signed({1'b0, center_y_r})) + (COORD_W+1)'(head.dy);
    lim_x = (COORD_W+1)'({1'b0, map_last_x_r});
    lim_y = (COORD_W+1)'({1'b0, map_last_y_r});
    inr   = !ax[COORD_W] && (ax <= lim_x) && !ay[COORD_W] && (ay <= lim_y);
    dd    = SCR_W'(head.dx - head.dy);
    ds    = SCR_W'(head.dx + head.dy + COORD_W'(2));
    sx    = SCR_W'(frame_width_r >> 1) + SCR_W'(dd * SCR_W'(HALF_W));
    sy    = SCR_W'(frame_height_r >> 1) - SCR_W'(1) + SCR_W'(ds * SCR_W'(HALF_H));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (req_go) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      out_tile_valid_r <= tile_ok;
      out_layer_r      <= tile_ok ? head.layer : '0;
      out_map_x_r      <= tile_ok ? ax[POS_W-1:0] : '0;
      out_map_y_r      <= tile_ok ? ay[POS_W-1:0] : '0;
      out_in_range_r   <= tile_ok && inr;
      out_screen_x_r   <= tile_ok ? sx : '0;
      out_screen_y_r   <= tile_ok ? sy : '0;
      out_row_last_r   <= tile_ok && head.row_last;
      out_frame_last_r <= tile_ok && head.frame_last;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.tile_valid = out_tile_valid_r;
  assign out_chan.layer      = out_layer_r;
  assign out_chan.map_x      = out_map_x_r;
  assign out_chan.map_y      = out_map_y_r;
  assign out_chan.in_range   = out_in_range_r;
  assign out_chan.screen_x   = out_screen_x_r;
  assign out_chan.screen_y   = out_screen_y_r;
  assign out_chan.row_last   = out_row_last_r;
  assign out_chan.frame_last = out_frame_last_r;

endmodule
